@@ rtl/core/pvd_pkg.sv @@
`timescale 1ns / 1ps

package pvd_pkg;

	localparam int unsigned ValueWidth = 32;
	localparam int unsigned ByteWidth  = 8;
	localparam int unsigned ExpWidth   = 4;

	// largest value that fits in three decimal digits
	localparam logic [ValueWidth-1:0] DigitLimit = 32'd999;
	// ceil(2^35 / 10): v / 10 == (v * Recip10) >> 35 for every 32-bit v
	localparam logic [ValueWidth-1:0] Recip10 = 32'hCCCC_CCCD;
	localparam logic [2:0] ExpMax = 3'd7;
	// lookup result when a two-digit value has no mantissa code
	localparam logic [4:0] MantNone = 5'd16;

	localparam logic [6:0] MantTable [16] = '{
		7'd10, 7'd12, 7'd13, 7'd15, 7'd20, 7'd25, 7'd30, 7'd35,
		7'd40, 7'd45, 7'd50, 7'd55, 7'd60, 7'd70, 7'd80, 7'd90
	};

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;     // take a new value, clear the exponent
		logic step;     // drop one decimal digit
		logic capture;  // register the descriptor bytes
		logic sel_ext;  // present the extension byte
	} pvd_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic strip_done;  // no more digits to drop
		logic has_ext;     // captured result carries an extension byte
	} pvd_sts_t;

	function automatic logic [4:0] mant_lookup(input logic [6:0] m);
		logic [4:0] idx;
		idx = MantNone;
		for (int k = 0; k < 16; k++) begin
			if (MantTable[k] == m) begin
				idx = 5'(k);
			end
		end
		return idx;
	endfunction

endpackage

@@ rtl/core/pvd_if.sv @@
`timescale 1ns / 1ps

interface pvd_value_if;
	logic        valid;
	logic        ready;
	logic [31:0] nominal_value;

	modport source (output valid, output nominal_value, input ready);
	modport sink   (input valid, input nominal_value, output ready);
endinterface

interface pvd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_byte;
	logic       range_error;

	modport source (output valid, output out_byte, output last_byte, output range_error,
		input ready);
	modport sink   (input valid, input out_byte, input last_byte, input range_error,
		output ready);
endinterface

@@ rtl/core/pvd_datapath.sv @@
`timescale 1ns / 1ps

module pvd_datapath
	import pvd_pkg::*;
(
	input  logic                  clk,
	input  pvd_cmd_t              cmd,
	input  logic [ValueWidth-1:0] nominal_value,
	output pvd_sts_t              sts,
	output logic [ByteWidth-1:0]  out_byte,
	output logic                  last_byte,
	output logic                  range_error
);

	logic [ValueWidth-1:0] v_q;
	logic [ExpWidth-1:0]   ex_q;
	logic [ByteWidth-1:0]  head_q;
	logic [6:0]            ext_q;
	logic                  err_q;
	logic                  has_ext_q;

	// divide by ten through the reciprocal
	logic [63:0]           prod;
	logic [ValueWidth-1:0] quo;
	logic [ValueWidth-1:0] rem;

	always_comb begin
		prod = 64'(v_q) * 64'(Recip10);
		quo  = 32'(prod[63:35]);
		rem  = v_q - ({quo[28:0], 3'b000} + {quo[30:0], 1'b0});
	end

	assign sts.strip_done = (v_q == '0) || ((rem[3:0] != 4'd0) && (v_q <= DigitLimit));
	assign sts.has_ext    = has_ext_q;

	// descriptor from the stripped value (at most three digits)
	logic [9:0]  v10;
	logic [6:0]  m1;
	logic [4:0]  idx1, idx2f, idx2, idx3, idx;
	logic [13:0] hp2;
	logic [3:0]  h2, h3;
	logic [6:0]  tens2, unit2, ext2, ext3, ext;
	logic [15:0] hp3;
	logic [9:0]  hund3;
	logic        dec;
	logic [3:0]  ex_f;
	logic        err;
	logic [7:0]  head;

	always_comb begin
		v10   = v_q[9:0];
		// single digit: scale up by ten
		m1    = {v10[3:0], 3'b000} + {2'b00, v10[3:0], 1'b0};
		idx1  = mant_lookup(m1);
		// two digits: direct code, or scale up and split
		idx2f = mant_lookup(v10[6:0]);
		hp2   = 14'(v10[6:0]) * 14'd103;
		h2    = hp2[13:10];
		tens2 = 7'(h2) * 7'd10;
		unit2 = v10[6:0] - tens2;
		ext2  = unit2 * 7'd10;
		idx2  = mant_lookup(tens2);
		// three digits: hundreds digit picks the code
		hp3   = 16'(v10) * 16'd41;
		h3    = hp3[15:12];
		hund3 = 10'(h3) * 10'd100;
		ext3  = 7'(v10 - hund3);
		idx3  = mant_lookup(7'(h3) * 7'd10);

		if (v10 < 10'd10) begin
			idx = idx1;
			ext = '0;
			dec = 1'b1;
		end else if (v10 < 10'd100) begin
			if (idx2f != MantNone) begin
				idx = idx2f;
				ext = '0;
				dec = 1'b0;
			end else begin
				idx = idx2;
				ext = ext2;
				dec = 1'b1;
			end
		end else begin
			idx = idx3;
			ext = ext3;
			dec = 1'b0;
		end

		ex_f = ex_q - 4'(dec);
		err  = (v_q == '0) || (dec && (ex_q == '0)) || (ex_f > 4'(ExpMax)) || idx[4];
		head = {(ext != '0), idx[3:0], ex_f[2:0]};
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			v_q  <= nominal_value;
			ex_q <= '0;
		end else if (cmd.step) begin
			v_q  <= quo;
			ex_q <= ex_q + 4'd1;
		end
		if (cmd.capture) begin
			head_q    <= err ? '0 : head;
			ext_q     <= err ? '0 : ext;
			err_q     <= err;
			has_ext_q <= !err && (ext != '0);
		end
	end

	assign out_byte    = cmd.sel_ext ? {1'b0, ext_q} : head_q;
	assign last_byte   = cmd.sel_ext || !has_ext_q;
	assign range_error = !cmd.sel_ext && err_q;

endmodule

@@ rtl/core/pvd_ctrl.sv @@
`timescale 1ns / 1ps

module pvd_ctrl
	import pvd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  pvd_sts_t sts,
	output pvd_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STRIP,
		ST_HEAD,
		ST_EXT
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;
	logic   sel_ext_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
			sel_ext_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready_q) begin
						state_q    <= ST_STRIP;
						in_ready_q <= 1'b0;
					end
				end
				ST_STRIP: begin
					if (sts.strip_done) begin
						state_q     <= ST_HEAD;
						out_valid_q <= 1'b1;
						sel_ext_q   <= 1'b0;
					end
				end
				ST_HEAD: begin
					if (out_ready) begin
						if (sts.has_ext) begin
							state_q   <= ST_EXT;
							sel_ext_q <= 1'b1;
						end else begin
							state_q     <= ST_IDLE;
							out_valid_q <= 1'b0;
							in_ready_q  <= 1'b1;
						end
					end
				end
				ST_EXT: begin
					if (out_ready) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b0;
						sel_ext_q   <= 1'b0;
						in_ready_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready    = in_ready_q;
	assign out_valid   = out_valid_q;
	assign cmd.load    = in_valid && in_ready_q;
	assign cmd.step    = (state_q == ST_STRIP) && !sts.strip_done;
	assign cmd.capture = (state_q == ST_STRIP) && sts.strip_done;
	assign cmd.sel_ext = sel_ext_q;

endmodule

@@ rtl/core/power_value_descriptor_encoder.sv @@
`timescale 1ns / 1ps

// channel    modport  payload                               per request
// value_ch   sink     nominal_value[31:0]                   one value to encode
// byte_ch    source   out_byte[7:0], last_byte, range_error one descriptor byte
//
// one value at a time: the value is taken, then its trailing decimal digits (0..9)
// are dropped one by one through the divide-by-ten step in the datapath, then the
// descriptor is built and one or two bytes are sent; no new value is taken until
// the last byte is accepted
// arst_n clears the controller only; datapath registers load before use
// a stall on byte_ch holds the current byte; value_ch stays not ready meanwhile

module power_value_descriptor_encoder
	import pvd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	pvd_value_if.sink     value_ch,
	pvd_byte_if.source    byte_ch
);

	pvd_cmd_t cmd;
	pvd_sts_t sts;

	// sequencing: idle, digit strip, head byte, extension byte
	pvd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (value_ch.valid),
		.in_ready  (value_ch.ready),
		.out_valid (byte_ch.valid),
		.out_ready (byte_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// value register, exponent counter, mantissa lookup and output bytes
	pvd_datapath u_datapath (
		.clk           (clk),
		.cmd           (cmd),
		.nominal_value (value_ch.nominal_value),
		.sts           (sts),
		.out_byte      (byte_ch.out_byte),
		.last_byte     (byte_ch.last_byte),
		.range_error   (byte_ch.range_error)
	);

	// no new request while a byte is still on offer
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		byte_ch.valid |-> !value_ch.ready)
		else $error("value channel ready while a byte is pending");

	// an error result is a single zero byte
	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		byte_ch.valid && byte_ch.range_error |-> byte_ch.last_byte && (byte_ch.out_byte == 8'd0))
		else $error("range error byte not final or not zero");

	// a head byte with the extension flag is followed by the final extension byte
	a_ext_follows: assert property (@(posedge clk) disable iff (!arst_n)
		byte_ch.valid && byte_ch.ready && !byte_ch.last_byte
		|=> byte_ch.valid && byte_ch.last_byte && !byte_ch.range_error)
		else $error("extension byte missing after head byte");

	// a head byte that is not final carries the extension flag
	a_ext_flag: assert property (@(posedge clk) disable iff (!arst_n)
		byte_ch.valid && !byte_ch.last_byte |-> byte_ch.out_byte[7])
		else $error("extension flag does not match last_byte");

endmodule

@@ tb/tb_power_value_descriptor_encoder.sv @@
`timescale 1ns / 1ps

module tb_power_value_descriptor_encoder;

	localparam int NoMantissa  = 16;
	localparam int MaxExponent = 7;
	localparam int CycleLimit  = 300000;
	localparam int RandomItems = 1130;
	localparam int MaxPrinted  = 40;

	// two-digit mantissa values, used to build well-formed stimulus
	localparam int unsigned MantValues [16] = '{
		10, 12, 13, 15, 20, 25, 30, 35,
		40, 45, 50, 55, 60, 70, 80, 90
	};

	// one descriptor byte as it appears on the result channel
	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_byte;
		logic       range_error;
	} desc_byte_t;

	// predicts the descriptor bytes of each accepted value and checks the
	// bytes that come out against them, in order
	class descriptor_scoreboard;
		desc_byte_t  expected_bytes[$];
		int unsigned mismatches;

		function new();
			mismatches = 0;
		endfunction

		function int mant_code(longint unsigned m);
			case (m)
				10: return 0;
				12: return 1;
				13: return 2;
				15: return 3;
				20: return 4;
				25: return 5;
				30: return 6;
				35: return 7;
				40: return 8;
				45: return 9;
				50: return 10;
				55: return 11;
				60: return 12;
				70: return 13;
				80: return 14;
				90: return 15;
				default: return NoMantissa;
			endcase
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction

		function void note_value(logic [31:0] value);
			longint unsigned digits;
			int              ex;
			int              idx;
			int unsigned     ext;
			desc_byte_t      head;
			desc_byte_t      tail;
			digits = value;
			ex     = 0;
			idx    = 0;
			ext    = 0;
			if (digits == 0) begin
				expected_bytes.push_back('{out_byte: 8'h00, last_byte: 1'b1, range_error: 1'b1});
				return;
			end
			while (digits % 10 == 0 || digits > 999) begin
				digits = digits / 10;
				ex++;
			end
			if (digits < 100) begin
				if (digits < 10) begin
					digits = digits * 10;
					ex--;
				end
				idx = mant_code(digits);
				if (idx == NoMantissa) begin
					digits = digits * 10;
					ex--;
				end
			end
			if (digits >= 100) begin
				idx = mant_code((digits / 100) * 10);
				ext = digits % 100;
			end
			if (ex < 0 || ex > MaxExponent || idx >= NoMantissa) begin
				expected_bytes.push_back('{out_byte: 8'h00, last_byte: 1'b1, range_error: 1'b1});
				return;
			end
			head.out_byte    = {ext != 0, idx[3:0], ex[2:0]};
			head.last_byte   = (ext == 0);
			head.range_error = 1'b0;
			expected_bytes.push_back(head);
			if (ext != 0) begin
				tail.out_byte    = ext[7:0];
				tail.last_byte   = 1'b1;
				tail.range_error = 1'b0;
				expected_bytes.push_back(tail);
			end
		endfunction

		task report_mismatch(string what, desc_byte_t got, desc_byte_t want);
			if (mismatches < MaxPrinted) begin
				$display("%0t mismatch %s: got byte %02h last %0b err %0b, want byte %02h last %0b err %0b",
					$realtime, what, got.out_byte, got.last_byte, got.range_error,
					want.out_byte, want.last_byte, want.range_error);
			end
			mismatches++;
		endtask

		task check_byte(desc_byte_t got);
			desc_byte_t want;
			if (expected_bytes.size() == 0) begin
				report_mismatch("unexpected byte", got, '0);
				return;
			end
			want = expected_bytes.pop_front();
			if (got.out_byte !== want.out_byte) begin
				report_mismatch("out_byte", got, want);
			end
			if (got.last_byte !== want.last_byte) begin
				report_mismatch("last_byte", got, want);
			end
			if (got.range_error !== want.range_error) begin
				report_mismatch("range_error", got, want);
			end
		endtask
	endclass

	logic clk;
	logic arst_n;

	pvd_value_if value_ch ();
	pvd_byte_if  byte_ch ();

	power_value_descriptor_encoder DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.value_ch (value_ch),
		.byte_ch  (byte_ch)
	);

	descriptor_scoreboard sb = new();

	logic [31:0]  stim_values[$];
	logic [15:0]  rx_tick = '0;
	int unsigned  cycle_count = 0;

	// 8 ns clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// watchdog: the slowest correct run is far below this
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// every accepted value request produces one or two expected bytes
	always @(posedge clk) begin
		if (arst_n && value_ch.valid && value_ch.ready) begin
			sb.note_value(value_ch.nominal_value);
		end
	end

	// each accepted byte request is checked against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && byte_ch.valid && byte_ch.ready) begin
			sb.check_byte('{out_byte: byte_ch.out_byte, last_byte: byte_ch.last_byte,
				range_error: byte_ch.range_error});
		end
	end

	// receiver back-pressure cycles through four phases, picked by rx_tick[8:7]:
	// always ready, mostly ready, mostly stalled, and ready when rx_tick is a multiple of three
	always @(posedge clk) begin
		rx_tick <= rx_tick + 16'd1;
		case (rx_tick[8:7])
			2'd0: begin
				byte_ch.ready <= 1'b1;
			end
			2'd1: begin
				byte_ch.ready <= ($urandom_range(0, 9) < 7);
			end
			2'd2: begin
				byte_ch.ready <= ($urandom_range(0, 9) < 3);
			end
			default: begin
				byte_ch.ready <= (rx_tick % 3 == 0);
			end
		endcase
	end

	// random value: mostly mantissa-shaped values scaled by powers of ten,
	// so that both the one-byte and two-byte paths and the exponent edges
	// are hit often; the rest is raw 32-bit noise and small values
	function automatic logic [31:0] random_value();
		longint unsigned v;
		int unsigned     k;
		int unsigned     kind;
		kind = $urandom_range(0, 9);
		k    = $urandom_range(0, 9);
		case (kind)
			0, 1: begin
				v = MantValues[$urandom_range(0, 15)];
			end
			2, 3: begin
				v = $urandom_range(100, 999);
			end
			4: begin
				v = $urandom_range(1, 9);
			end
			5: begin
				v = $urandom_range(0, 150);
				k = 0;
			end
			6, 7: begin
				v = $urandom();
				k = 0;
			end
			8: begin
				v = $urandom_range(0, 99999);
				k = 0;
			end
			default: begin
				v = $urandom_range(1000, 99999);
			end
		endcase
		// scale up while the value still fits in 32 bits
		repeat (k) begin
			if (v * 10 <= 64'hFFFF_FFFF) begin
				v = v * 10;
			end
		end
		return v[31:0];
	endfunction

	// sender: bursts of random length, separated by random gaps; about half
	// the bursts follow the previous one with no gap at all
	task automatic send_values();
		int unsigned burst_left;
		int unsigned gap;
		burst_left = 0;
		foreach (stim_values[i]) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 7);
				if (gap != 0) begin
					value_ch.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			value_ch.valid         <= 1'b1;
			value_ch.nominal_value <= stim_values[i];
			@(posedge clk);
			while (!value_ch.ready) begin
				@(posedge clk);
			end
			burst_left--;
		end
		value_ch.valid <= 1'b0;
	endtask

	initial begin
		arst_n                 <= 1'b0;
		value_ch.valid         <= 1'b0;
		value_ch.nominal_value <= '0;

		// zero, single digits and non-table two-digit values (exponent below zero)
		stim_values.push_back(32'd0);
		stim_values.push_back(32'd1);
		stim_values.push_back(32'd9);
		stim_values.push_back(32'd11);
		stim_values.push_back(32'd14);
		stim_values.push_back(32'd99);
		stim_values.push_back(32'd37);
		// table mantissas, scaled table values and values with an extension byte
		stim_values.push_back(32'd10);
		stim_values.push_back(32'd12);
		stim_values.push_back(32'd45);
		stim_values.push_back(32'd90);
		stim_values.push_back(32'd100);
		stim_values.push_back(32'd110);
		stim_values.push_back(32'd370);
		stim_values.push_back(32'd999);
		stim_values.push_back(32'd1234);
		stim_values.push_back(32'd2500);
		// exponent at six, at seven and just above it
		stim_values.push_back(32'd100000000);
		stim_values.push_back(32'd900000000);
		stim_values.push_back(32'd999999999);
		stim_values.push_back(32'd1000000000);
		stim_values.push_back(32'd4000000000);
		stim_values.push_back(32'h8000_0000);
		stim_values.push_back(32'hFFFF_FFFF);
		repeat (RandomItems) begin
			stim_values.push_back(random_value());
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_values();

		// drain, then allow time for any stray byte to show up
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (32) @(posedge clk);

		if (sb.mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
